@@ rtl/bsr_pkg.sv @@
`default_nettype none

package bsr_pkg;

  localparam int DATA_W       = 32;
  localparam int IDX_W        = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int U_POINTS_DEF = 257;

  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sd65536;
  localparam logic signed [DATA_W-1:0] Q_THREE = 32'sd196608;
  localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh80000000;

  localparam logic signed [DATA_W-1:0] A_COEF_RST      = 32'sd65536;
  localparam logic signed [DATA_W-1:0] B_COEF_RST      = 32'sd196608;
  localparam logic signed [DATA_W-1:0] DIFF_U_GAIN_RST = 32'sd87246766;
  localparam logic signed [DATA_W-1:0] DIFF_V_GAIN_RST = 32'sd21811692;

  localparam logic [CFG_IDX_W-1:0] CFG_A_COEF      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COEF      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_U_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_V_GAIN = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // saturated value and its flag
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [47:0] v);
    sat_t r;
    r.ovf = (v[47:31] != {17{v[47]}});
    r.val = r.ovf ? (v[47] ? Q_MIN : Q_MAX) : v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bsr_in_if.sv @@
`default_nettype none

interface bsr_in_if;
  import bsr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, index, value, input ready);
  modport sink   (input valid, kind, index, value, output ready);
endinterface

`default_nettype wire

@@ rtl/bsr_out_if.sv @@
`default_nettype none

interface bsr_out_if;
  import bsr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] rate_out;
  logic                     overflow;

  modport source (output valid, rate_out, overflow, input ready);
  modport sink   (input valid, rate_out, overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/brusselator_staggered_rhs.sv @@
`default_nettype none

// Load item, or evaluate at an index outside the store: the sequencer goes straight to the done
// state, and the next item is taken once the result has moved into a free output beat slot.
// Evaluate item: read steps, then calc steps, then the done state; their length is set by
// five reads through the single store read port and four products on the shared multiplier.
// A waiting result does not stop the next item from being taken.
// Reset (async, active low) clears control and restores the coefficients, not the store.

module brusselator_staggered_rhs #(
  parameter int U_POINTS = bsr_pkg::U_POINTS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bsr_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic signed [bsr_pkg::DATA_W-1:0]     cfg_data_i,
  bsr_in_if.sink                                    in_i,
  bsr_out_if.source                                 out_o
);
  import bsr_pkg::*;

  localparam int V_POINTS = (U_POINTS - 1) / 2;
  localparam int DEPTH    = U_POINTS + V_POINTS;
  localparam int AW       = $clog2(DEPTH);
  // compare width: holds both the index field and the store depth
  localparam int CW       = ((AW > IDX_W) ? AW : IDX_W) + 1;

  localparam logic [AW-1:0] U_BASE = AW'(U_POINTS);
  localparam logic [AW-1:0] U_LAST = AW'(U_POINTS - 1);
  localparam logic [AW-1:0] V_NUM  = AW'(V_POINTS);
  localparam logic [AW-1:0] V_LAST = AW'(V_POINTS - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // read slots: 0 centre, 1 left, 2 right, 3 left v (u) / u (v), 4 right v (u)
  localparam logic [2:0] RD_LAST = 3'd4;
  // calc steps
  localparam logic [2:0] C_SQ    = 3'd0;  // issue centre squared, seed accumulator, laplacian
  localparam logic [2:0] C_BX    = 3'd1;  // take square, issue B times centre, v average
  localparam logic [2:0] C_CUBE  = 3'd2;  // add B term, issue square times coupling
  localparam logic [2:0] C_DIFF  = 3'd3;  // add cubic term, issue gain times laplacian
  localparam logic [2:0] C_SUM   = 3'd4;  // add diffusion term
  localparam logic [2:0] C_FIN   = 3'd5;  // clamp the sum

  // configuration
  logic signed [DATA_W-1:0] a_coef_q, b_coef_q, du_gain_q, dv_gain_q;

  // control
  logic [1:0] state_q;
  logic [2:0] step_q;
  logic       cap_vld_q;
  logic       out_valid_q;

  // datapath
  logic [AW-1:0]            cen_q;
  logic                     is_v_q;
  logic [2:0]               cap_step_q;
  logic                     cap_const_q;
  logic signed [DATA_W-1:0] cap_cval_q;
  logic signed [DATA_W-1:0] vals_q [5];
  logic signed [DATA_W-1:0] lap_q, lin_q, m1_q;
  logic signed [35:0]       acc_q;
  logic                     flag_q;
  logic signed [DATA_W-1:0] res_rate_q, out_rate_q;
  logic                     res_ovf_q, out_ovf_q;

  // input decode
  logic [CW-1:0] idx_w;
  logic          idx_in_rng, idx_is_v, in_acc;
  logic [AW-1:0] in_addr;

  assign idx_w      = CW'(in_i.index);
  assign idx_in_rng = (idx_w < CW'(DEPTH));
  assign idx_is_v   = (idx_w >= CW'(U_POINTS));
  assign in_addr    = idx_w[AW-1:0];
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // read address generation
  logic [AW-1:0]            half, k1, vk, rd_addr;
  logic                     rd_const, rd_en;
  logic signed [DATA_W-1:0] rd_cval, rdata;

  assign half  = cen_q >> 1;
  assign k1    = cen_q[0] ? half : (half - AW'(1));
  assign vk    = cen_q - U_BASE;
  assign rd_en = (state_q == S_RD);

  always_comb begin
    rd_addr  = cen_q;
    rd_const = 1'b0;
    rd_cval  = Q_ONE;
    if (!is_v_q) begin
      unique case (step_q)
        3'd1: begin
          rd_addr  = cen_q - AW'(1);
          rd_const = (cen_q == '0);
          rd_cval  = Q_ONE;
        end
        3'd2: begin
          rd_addr  = cen_q + AW'(1);
          rd_const = (cen_q == U_LAST);
          rd_cval  = Q_ONE;
        end
        3'd3: begin
          rd_addr  = U_BASE + k1;
          rd_const = (cen_q == '0);
          rd_cval  = Q_THREE;
        end
        3'd4: begin
          rd_addr  = U_BASE + half;
          rd_const = (half >= V_NUM);
          rd_cval  = Q_THREE;
        end
        default: begin
          rd_addr  = cen_q;
        end
      endcase
    end else begin
      unique case (step_q)
        3'd1: begin
          rd_addr  = cen_q - AW'(1);
          rd_const = (vk == '0);
          rd_cval  = Q_THREE;
        end
        3'd2: begin
          rd_addr  = cen_q + AW'(1);
          rd_const = (vk == V_LAST);
          rd_cval  = Q_THREE;
        end
        3'd3: begin
          rd_addr  = {vk[AW-2:0], 1'b1};  // u at 2k+1
        end
        3'd4: begin
          rd_const = 1'b1;                // slot unused for v points
          rd_cval  = '0;
        end
        default: begin
          rd_addr  = cen_q;
        end
      endcase
    end
  end

  bsr_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_i.kind == KIND_LOAD) && idx_in_rng),
    .waddr_i (in_addr),
    .wdata_i (in_i.value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // shared multiplier
  logic signed [DATA_W-1:0] sq, gain, mul_a, mul_b;
  sat_t                     mres;

  assign sq   = is_v_q ? vals_q[3] : vals_q[0];
  assign gain = is_v_q ? dv_gain_q : du_gain_q;

  always_comb begin
    unique case (step_q)
      C_BX:    begin mul_a = b_coef_q;  mul_b = sq;    end
      C_CUBE:  begin mul_a = m1_q;      mul_b = lin_q; end
      C_DIFF:  begin mul_a = gain;      mul_b = lap_q; end
      default: begin mul_a = sq;        mul_b = sq;    end
    endcase
  end

  bsr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mres)
  );

  // adders: laplacian, v average, accumulator clamp
  logic signed [33:0] lap_raw;
  logic signed [32:0] vsum;
  sat_t               lap_s, acc_s;
  logic signed [35:0] m_ext;

  assign lap_raw = 34'(vals_q[1]) + 34'(vals_q[2]) - (34'(vals_q[0]) <<< 1);
  assign lap_s   = sat32(48'(lap_raw));
  assign vsum    = 33'(vals_q[3]) + 33'(vals_q[4]);
  assign acc_s   = sat32(48'(acc_q));
  assign m_ext   = 36'(mres.val);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cap_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      a_coef_q    <= A_COEF_RST;
      b_coef_q    <= B_COEF_RST;
      du_gain_q   <= DIFF_U_GAIN_RST;
      dv_gain_q   <= DIFF_V_GAIN_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_A_COEF:      a_coef_q  <= cfg_data_i;
          CFG_B_COEF:      b_coef_q  <= cfg_data_i;
          CFG_DIFF_U_GAIN: du_gain_q <= cfg_data_i;
          CFG_DIFF_V_GAIN: dv_gain_q <= cfg_data_i;
        endcase
      end

      cap_vld_q <= rd_en;

      // a new beat replaces the one taken this edge; otherwise a taken beat clears
      if ((state_q == S_DONE) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            step_q <= '0;
            if ((in_i.kind == KIND_EVAL) && idx_in_rng) begin
              state_q <= S_RD;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_RD: begin
          if (step_q == RD_LAST) begin
            step_q  <= '0;
            state_q <= S_CALC;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_CALC: begin
          if (step_q == C_FIN) begin
            step_q  <= '0;
            state_q <= S_DONE;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_DONE: begin
          // hand over once the output beat slot is free
          if (!out_valid_q || out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cen_q      <= in_addr;
      is_v_q     <= idx_is_v;
      res_rate_q <= '0;
      res_ovf_q  <= 1'b0;
    end

    if (rd_en) begin
      cap_step_q  <= step_q;
      cap_const_q <= rd_const;
      cap_cval_q  <= rd_cval;
    end

    if (cap_vld_q) begin
      vals_q[cap_step_q] <= cap_const_q ? cap_cval_q : rdata;
    end

    if (state_q == S_CALC) begin
      unique case (step_q)
        C_SQ: begin
          lap_q  <= lap_s.val;
          flag_q <= lap_s.ovf;
          acc_q  <= is_v_q ? '0 : (36'(a_coef_q) - 36'(vals_q[0]));
        end
        C_BX: begin
          m1_q   <= mres.val;
          flag_q <= flag_q | mres.ovf;
          lin_q  <= is_v_q ? vals_q[0] : vsum[32:1];
        end
        C_CUBE: begin
          flag_q <= flag_q | mres.ovf;
          acc_q  <= is_v_q ? (acc_q + m_ext) : (acc_q - m_ext);
        end
        C_DIFF: begin
          flag_q <= flag_q | mres.ovf;
          acc_q  <= is_v_q ? (acc_q - m_ext) : (acc_q + m_ext);
        end
        C_SUM: begin
          flag_q <= flag_q | mres.ovf;
          acc_q  <= acc_q + m_ext;
        end
        C_FIN: begin
          res_rate_q <= acc_s.val;
          res_ovf_q  <= flag_q | acc_s.ovf;
        end
        default: begin
          flag_q <= flag_q;
        end
      endcase
    end

    if ((state_q == S_DONE) && (!out_valid_q || out_o.ready)) begin
      out_rate_q <= res_rate_q;
      out_ovf_q  <= res_ovf_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.rate_out = out_rate_q;
  assign out_o.overflow = out_ovf_q;

endmodule

`default_nettype wire

@@ rtl/bsr_store.sv @@
`default_nettype none

module bsr_store #(
  parameter int DEPTH = 385,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [AW-1:0]                    waddr_i,
  input  wire logic signed [bsr_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                             re_i,
  input  wire logic [AW-1:0]                    raddr_i,
  output logic signed [bsr_pkg::DATA_W-1:0]      rdata_o
);
  import bsr_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/bsr_mul.sv @@
`default_nettype none

module bsr_mul (
  input  wire logic                              clk_i,
  input  wire logic signed [bsr_pkg::DATA_W-1:0] a_i,
  input  wire logic signed [bsr_pkg::DATA_W-1:0] b_i,
  output bsr_pkg::sat_t                          res_o
);
  import bsr_pkg::*;

  logic signed [2*DATA_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Q16.16 rescale: floor shift by 16, then clamp
  assign res_o = sat32(prod_q[63:16]);

endmodule

`default_nettype wire

@@ rtl/bsr_checker.sv @@
`default_nettype none

module bsr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready after acceptance");

  // ready only drops because an item was taken
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("input ready dropped without an accepted beat");

  // a new result appears only as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result offered while sequencer busy");

endmodule

bind brusselator_staggered_rhs bsr_checker u_bsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import bsr_pkg::*;

  localparam int UP       = U_POINTS_DEF;
  localparam int VP       = (UP - 1) / 2;
  localparam int DEPTH    = UP + VP;
  localparam int LIMIT_NS = 10_000_000;
  localparam int SETTLE   = 15;   // evaluate latency plus margin
  localparam int PHASES   = 6;
  localparam int PER_PHASE = 150;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] rate;
    logic                     ovf;
  } rate_beat_t;

  // directed row: expected result is used only where typed is set
  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         idx;
    logic [DATA_W-1:0]        val;
    logic                     typed;
    logic signed [DATA_W-1:0] rate;
    logic                     ovf;
  } stim_row_t;

  localparam int N_DIRECTED = 22;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic signed [DATA_W-1:0] cfg_data_i;

  bsr_in_if  in_bus ();
  bsr_out_if out_bus ();

  brusselator_staggered_rhs i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mirror of the grid store and the coefficients
  logic signed [DATA_W-1:0] grid_mirror [DEPTH];
  bit                       grid_loaded [DEPTH];
  logic signed [DATA_W-1:0] coef_a  = A_COEF_RST;
  logic signed [DATA_W-1:0] coef_b  = B_COEF_RST;
  logic signed [DATA_W-1:0] gain_u  = DIFF_U_GAIN_RST;
  logic signed [DATA_W-1:0] gain_v  = DIFF_V_GAIN_RST;

  rate_beat_t rates_due [$];

  int err_count  = 0;
  int n_loads    = 0;
  int n_evals    = 0;
  int n_sat      = 0;
  int n_settings = 0;
  int n_counted  = 0;
  int tx_calm    = 0;
  int rx_calm    = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // after reset: loads answer zero
    '{KIND_LOAD, 9'd0,   32'd0,        1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd1,   Q_ONE,        1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd257, Q_THREE,      1'b1, 32'sd0, 1'b0},
    // x = 0, both u neighbours 1.0: A + 2 * diff_u_gain
    '{KIND_EVAL, 9'd0,   32'd0,        1'b1, 32'sd174559068, 1'b0},
    // outside the store: zero and no flag, loads dropped
    '{KIND_EVAL, 9'd511, 32'hffffffff, 1'b1, 32'sd0, 1'b0},
    '{KIND_EVAL, 9'd385, 32'd0,        1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd385, 32'hffffffff, 1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd511, 32'h80000000, 1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd2,   Q_MAX,        1'b1, 32'sd0, 1'b0},
    '{KIND_EVAL, 9'd1,   32'd0,        1'b0, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd3,   Q_MIN,        1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd258, Q_MIN,        1'b1, 32'sd0, 1'b0},
    '{KIND_EVAL, 9'd2,   32'd0,        1'b0, 32'sd0, 1'b0},
    '{KIND_EVAL, 9'd257, 32'd0,        1'b0, 32'sd0, 1'b0},
    // right-hand end of both grids
    '{KIND_LOAD, 9'd254, 32'd0,        1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd255, 32'hffff0000, 1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd256, Q_MAX,        1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd383, Q_ONE,        1'b1, 32'sd0, 1'b0},
    '{KIND_LOAD, 9'd384, Q_MIN,        1'b1, 32'sd0, 1'b0},
    '{KIND_EVAL, 9'd256, 32'd0,        1'b0, 32'sd0, 1'b0},
    '{KIND_EVAL, 9'd255, 32'd0,        1'b0, 32'sd0, 1'b0},
    '{KIND_EVAL, 9'd384, 32'd0,        1'b0, 32'sd0, 1'b0}
  };

  function automatic longint clamp32(input longint v, inout bit f);
    if (v > S32_HI) begin
      f = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      f = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  // Q16.16 product, floor then saturate
  function automatic longint qmul(input longint p, input longint q, inout bit f);
    return clamp32((p * q) >>> 16, f);
  endfunction

  function automatic longint fetch(input int e);
    longint v;
    v = grid_mirror[e];
    return v;
  endfunction

  function automatic longint u_point_rate(input int i, inout bit f);
    longint x, l, r, vl, vr, avg, lap, s;
    int k1, k2;
    x = fetch(i);
    l = (i == 0) ? longint'(Q_ONE) : fetch(i - 1);
    r = (i == UP - 1) ? longint'(Q_ONE) : fetch(i + 1);
    if (i % 2 == 0) begin
      k1 = i / 2 - 1;
      k2 = i / 2;
    end else begin
      k1 = (i - 1) / 2;
      k2 = k1;
    end
    vl  = (k1 < 0) ? longint'(Q_THREE) : fetch(UP + k1);
    vr  = (k2 >= VP) ? longint'(Q_THREE) : fetch(UP + k2);
    avg = (vl + vr) >>> 1;
    lap = clamp32(l - 2 * x + r, f);
    s = longint'(coef_a) + qmul(qmul(x, x, f), avg, f) - qmul(coef_b, x, f) - x
        + qmul(gain_u, lap, f);
    return clamp32(s, f);
  endfunction

  function automatic longint v_point_rate(input int k, inout bit f);
    longint v, u, l, r, lap, s;
    v = fetch(UP + k);
    u = fetch(2 * k + 1);
    l = (k == 0) ? longint'(Q_THREE) : fetch(UP + k - 1);
    r = (k == VP - 1) ? longint'(Q_THREE) : fetch(UP + k + 1);
    lap = clamp32(l - 2 * v + r, f);
    s = qmul(coef_b, u, f) - qmul(qmul(u, u, f), v, f) + qmul(gain_v, lap, f);
    return clamp32(s, f);
  endfunction

  // applies one beat to the mirror and returns the rate it must produce
  function automatic rate_beat_t predict_rate(input logic kind, input logic [IDX_W-1:0] idx,
                                              input logic signed [DATA_W-1:0] val);
    rate_beat_t res;
    bit f;
    longint s;
    int i;
    f = 1'b0;
    s = 0;
    i = int'(idx);
    if (kind == KIND_LOAD) begin
      if (i < DEPTH) begin
        grid_mirror[i] = val;
        grid_loaded[i] = 1'b1;
      end
    end else if (i < UP) begin
      s = u_point_rate(i, f);
    end else if (i < DEPTH) begin
      s = v_point_rate(i - UP, f);
    end
    res.rate = s[31:0];
    res.ovf  = f;
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones, now and then a calm run
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(40, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] small_q(input int span);
    return int'($urandom_range(0, 2 * span * 65536)) - span * 65536;
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return small_q(4);
    if (r == 5) begin
      case ($urandom_range(0, 4))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return '0;
        3: return Q_ONE;
        default: return -Q_ONE;
      endcase
    end
    return $urandom;
  endfunction

  function automatic int draw_eval_index();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 8))
        0: return 0;
        1: return 1;
        2: return 2;
        3: return UP - 2;
        4: return UP - 1;
        5: return UP;
        6: return UP + 1;
        7: return DEPTH - 2;
        default: return DEPTH - 1;
      endcase
    end
    return $urandom_range(0, DEPTH - 1);
  endfunction

  function automatic bit log_error();
    err_count++;
    return err_count <= 10;
  endfunction

  // one beat on the input channel; prediction taken at the accepting edge
  task automatic push_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val, input logic typed,
                           input logic signed [DATA_W-1:0] t_rate, input logic t_ovf);
    int gap;
    rate_beat_t want;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind  <= kind;
    in_bus.index <= idx;
    in_bus.value <= val;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    want = predict_rate(kind, idx, val);
    if (typed) begin
      want.rate = t_rate;
      want.ovf  = t_ovf;
    end
    rates_due.push_back(want);
    if (kind == KIND_LOAD) n_loads++;
    else n_evals++;
    if (!(kind == KIND_LOAD && int'(idx) >= DEPTH)) n_counted++;
  endtask

  // load every entry an evaluation at idx will read, where not yet loaded
  task automatic prime_reads(input int idx);
    int need [6];
    int n, k;
    n = 0;
    if (idx < UP) begin
      need[n] = idx; n++;
      if (idx > 0) begin need[n] = idx - 1; n++; end
      if (idx < UP - 1) begin need[n] = idx + 1; n++; end
      if (idx % 2 == 0) begin
        if (idx > 0) begin need[n] = UP + idx / 2 - 1; n++; end
        if (idx / 2 < VP) begin need[n] = UP + idx / 2; n++; end
      end else begin
        need[n] = UP + (idx - 1) / 2; n++;
      end
    end else begin
      k = idx - UP;
      need[n] = idx; n++;
      need[n] = 2 * k + 1; n++;
      if (k > 0) begin need[n] = idx - 1; n++; end
      if (k < VP - 1) begin need[n] = idx + 1; n++; end
    end
    for (int j = 0; j < n; j++) begin
      if (!grid_loaded[need[j]])
        push_item(KIND_LOAD, IDX_W'(need[j]), draw_value(), 1'b0, '0, 1'b0);
    end
  endtask

  // drop valid, drain every result, let the pipe settle
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (rates_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic signed [DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_A_COEF:      coef_a = d;
      CFG_B_COEF:      coef_b = d;
      CFG_DIFF_U_GAIN: gain_u = d;
      default:         gain_v = d;
    endcase
  endtask

  task automatic apply_setting(input int p);
    logic signed [DATA_W-1:0] a, b, du, dv;
    case (p)
      0: begin a = $urandom; b = $urandom; du = $urandom; dv = $urandom; end
      1: begin a = Q_MAX; b = Q_MAX; du = Q_MAX; dv = Q_MAX; end
      2: begin a = Q_MIN; b = Q_MIN; du = Q_MIN; dv = Q_MIN; end
      3: begin a = '0; b = '0; du = '0; dv = '0; end
      4: begin
        a  = small_q(4);
        b  = small_q(4);
        du = int'($urandom_range(0, 1 << 27)) - (1 << 26);
        dv = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      end
      default: begin
        a = A_COEF_RST; b = B_COEF_RST; du = DIFF_U_GAIN_RST; dv = DIFF_V_GAIN_RST;
      end
    endcase
    wait_idle();
    write_coef(CFG_A_COEF, a);
    write_coef(CFG_B_COEF, b);
    write_coef(CFG_DIFF_U_GAIN, du);
    write_coef(CFG_DIFF_V_GAIN, dv);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // mostly evaluations over a primed neighbourhood, plus loads and stray indices
  task automatic random_phase(input int budget);
    int start, pick, idx;
    start = n_counted;
    while (n_counted - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_item(1'($urandom_range(0, 1)), IDX_W'($urandom_range(DEPTH, 511)), $urandom,
                  1'b0, '0, 1'b0);
      end else if (pick < 35) begin
        push_item(KIND_LOAD, IDX_W'($urandom_range(0, DEPTH - 1)), draw_value(),
                  1'b0, '0, 1'b0);
      end else begin
        idx = draw_eval_index();
        prime_reads(idx);
        push_item(KIND_EVAL, IDX_W'(idx), $urandom, 1'b0, '0, 1'b0);
      end
    end
  endtask

  // result side: random back-pressure and the scoreboard
  initial begin
    int stall;
    bit beat;
    rate_beat_t want;
    stall = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      beat = out_bus.valid && out_bus.ready;
      if (beat) begin
        if (out_bus.overflow) n_sat++;
        if (rates_due.size() == 0) begin
          if (log_error())
            $display("tb: result with nothing due: rate %0d ovf %0b",
                     out_bus.rate_out, out_bus.overflow);
        end else begin
          want = rates_due.pop_front();
          if (out_bus.rate_out !== want.rate) begin
            if (log_error())
              $display("tb: rate_out mismatch: expected %0d (%h), got %0d (%h)",
                       want.rate, want.rate, out_bus.rate_out, out_bus.rate_out);
          end
          if (out_bus.overflow !== want.ovf) begin
            if (log_error())
              $display("tb: overflow mismatch: expected %0b, got %0b",
                       want.ovf, out_bus.overflow);
          end
        end
        stall = pick_gap(rx_calm);
      end else if (stall > 0) begin
        stall--;
      end else if ($urandom_range(0, 15) == 0) begin
        stall = pick_gap(rx_calm);
      end
      out_bus.ready <= (stall == 0);
    end
  end

  // stimulus
  initial begin
    int guard;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_A_COEF;
    cfg_data_i    = '0;
    in_bus.valid  = 1'b0;
    in_bus.kind   = KIND_LOAD;
    in_bus.index  = '0;
    in_bus.value  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows run on the reset coefficients
    for (int r = 0; r < N_DIRECTED; r++) begin
      push_item(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].val,
                directed_rows[r].typed, directed_rows[r].rate, directed_rows[r].ovf);
    end

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(p);
      random_phase(PER_PHASE);
    end

    in_bus.valid <= 1'b0;
    guard = 0;
    while (rates_due.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (rates_due.size() != 0) begin
      $display("tb: %0d results never arrived", rates_due.size());
      err_count += rates_due.size();
    end

    $display("tb: %0d loads and %0d evaluations over %0d coefficient settings",
             n_loads, n_evals, n_settings + 1);
    $display("tb: %0d saturated results, %0d mismatches", n_sat, err_count);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("tb: run limit reached, %0d results still due", rates_due.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
